/* rtl/pli_pkg.sv */
// shared types and codes for the piecewise linear interpolation core
package pli_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [1:0] K_DIRECT = 2'd0;
    localparam logic [1:0] K_WRITE  = 2'd1;
    localparam logic [1:0] K_QUERY  = 2'd2;

    localparam logic [7:0] Y_MAX = 8'd255;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] status;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] qx;
    } t_cmd;

endpackage

/* rtl/pli_if.sv */
// item channels of the interpolation core
interface pli_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] point_x;
    logic [7:0] point_y;
    logic [7:0] query_x;
    modport source (output valid, action, point_x, point_y, query_x, input ready);
    modport sink   (input valid, action, point_x, point_y, query_x, output ready);
endinterface

interface pli_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] result_y;
    logic [1:0] status;
    modport source (output valid, result_y, status, input ready);
    modport sink   (input valid, result_y, status, output ready);
endinterface

/* rtl/pli_ram.sv */
// generic single port ram with registered read
module pli_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/pli_front.sv */
// front end: accepts items, tracks the point count and classifies each item
module pli_front #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF,
    localparam int CW = $clog2(MAX_POINTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pli_in_if.sink        i_item,
    input  logic          i_full,
    output logic          o_push,
    output pli_pkg::t_cmd o_cmd,
    output logic [CW-1:0] o_cnt
);
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    pli_pkg::t_cmd cmd;

    assign i_item.ready = !i_full;
    assign o_push = i_item.valid && !i_full;

    always_comb begin
        n_cnt = r_cnt;
        cmd.kind = pli_pkg::K_DIRECT;
        cmd.status = pli_pkg::ST_OK;
        cmd.x = i_item.point_x;
        cmd.y = i_item.point_y;
        cmd.qx = i_item.query_x;
        unique case (i_item.action)
            pli_pkg::ACT_CLEAR: begin
                n_cnt = '0;
            end
            pli_pkg::ACT_APPEND: begin
                if (r_cnt < CW'(MAX_POINTS)) begin
                    cmd.kind = pli_pkg::K_WRITE;
                    n_cnt = r_cnt + CW'(1);
                end else begin
                    cmd.status = pli_pkg::ST_FULL;
                end
            end
            pli_pkg::ACT_QUERY: begin
                if (r_cnt == '0) begin
                    cmd.status = pli_pkg::ST_EMPTY;
                end else begin
                    cmd.kind = pli_pkg::K_QUERY;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_cmd = cmd;
    assign o_cnt = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_push) begin
            r_cnt <= n_cnt;
        end
    end
endmodule

/* rtl/pli_queue.sv */
// two entry queue between front and back
module pli_queue #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_full = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

/* rtl/pli_back.sv */
// back end: table writes, segment scan, multiply, serial divide, saturation
module pli_back #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF,
    localparam int CW = $clog2(MAX_POINTS + 1),
    localparam int IW = $clog2(MAX_POINTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  pli_pkg::t_cmd i_cmd,
    input  logic [CW-1:0] i_cnt,
    output logic          o_pop,
    pli_out_if.source     o_result
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ONE  = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_FA   = 4'd3;
    localparam logic [3:0] S_FB   = 4'd4;
    localparam logic [3:0] S_FC   = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_SGN  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0]         r_state;
    logic [IW-1:0]      r_seg;
    logic [CW-1:0]      r_cnt;
    logic [7:0]         r_qx;
    logic [7:0]         r_xa, r_ya, r_xb, r_yb;
    logic signed [17:0] r_prod;
    logic signed [8:0]  r_den;
    logic [15:0]        r_quo;
    logic [8:0]         r_rem;
    logic [7:0]         r_dmag;
    logic               r_neg;
    logic [3:0]         r_step;
    logic               r_ov;
    logic [7:0]         r_res;
    logic [1:0]         r_st;

    logic               we;
    logic [IW-1:0]      addr;
    logic [15:0]        rdata;
    logic               free;
    logic               take;
    logic               set_ov;
    logic [7:0]         rx, ry;
    logic [CW-1:0]      seg_next;
    logic [CW-1:0]      seg_sel;
    logic [CW-1:0]      lim;
    logic signed [8:0]  dy, dq;
    logic [8:0]         rem2;
    logic signed [16:0] qs;
    logic signed [17:0] rc;
    logic [17:0]        pmag;

    assign rx = rdata[15:8];
    assign ry = rdata[7:0];
    assign free = !r_ov || o_result.ready;
    assign take = r_state == S_IDLE && i_valid && free;
    assign o_pop = take;
    assign we = take && i_cmd.kind == pli_pkg::K_WRITE;

    // a result item is loaded this cycle
    assign set_ov = (take && i_cmd.kind != pli_pkg::K_QUERY) || r_state == S_ONE
                    || (r_state == S_MUL && r_xa == r_xb) || r_state == S_FIN;

    assign seg_next = CW'(r_seg) + CW'(1);
    assign lim = r_cnt - CW'(2);

    always_comb begin
        seg_sel = (r_seg == '0) ? '0 : CW'(r_seg) - CW'(1);
        if (seg_sel > lim) begin
            seg_sel = lim;
        end
    end

    always_comb begin
        priority case (1'b1)
            take:              addr = we ? i_cnt[IW-1:0] : '0;
            r_state == S_SCAN: addr = seg_next[IW-1:0];
            r_state == S_FB:   addr = r_seg + IW'(1);
            default:           addr = r_seg;
        endcase
    end

    pli_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (addr),
        .i_wdata ({i_cmd.x, i_cmd.y}),
        .o_rdata (rdata)
    );

    assign dy = $signed({1'b0, r_yb}) - $signed({1'b0, r_ya});
    assign dq = $signed({1'b0, r_qx}) - $signed({1'b0, r_xa});
    assign rem2 = {r_rem[7:0], r_quo[15]};
    assign qs = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign rc = $signed({10'd0, r_ya}) + 18'(qs);
    assign pmag = r_prod[17] ? 18'(-r_prod) : 18'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (set_ov) begin
            r_ov <= 1'b1;
        end else if (o_result.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_cnt <= i_cnt;
                        r_qx <= i_cmd.qx;
                        r_seg <= '0;
                        if (i_cmd.kind == pli_pkg::K_QUERY) begin
                            r_state <= (i_cnt == CW'(1)) ? S_ONE : S_SCAN;
                        end else begin
                            r_res <= '0;
                            r_st <= i_cmd.status;
                        end
                    end
                end
                S_ONE: begin
                    r_res <= ry;
                    r_st <= pli_pkg::ST_OK;
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    if (r_qx >= rx) begin
                        r_seg <= seg_sel[IW-1:0];
                        r_state <= S_FA;
                    end else if (seg_next == r_cnt) begin
                        r_seg <= lim[IW-1:0];
                        r_state <= S_FA;
                    end else begin
                        r_seg <= seg_next[IW-1:0];
                    end
                end
                S_FA: begin
                    r_state <= S_FB;
                end
                S_FB: begin
                    r_xa <= rx;
                    r_ya <= ry;
                    r_state <= S_FC;
                end
                S_FC: begin
                    r_xb <= rx;
                    r_yb <= ry;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_xa == r_xb) begin
                        r_res <= r_ya;
                        r_st <= pli_pkg::ST_OK;
                        r_state <= S_IDLE;
                    end else begin
                        r_prod <= 18'(dy * dq);
                        r_den <= $signed({1'b0, r_xb}) - $signed({1'b0, r_xa});
                        r_state <= S_SGN;
                    end
                end
                S_SGN: begin
                    r_quo <= pmag[15:0];
                    r_dmag <= r_den[8] ? 8'(-r_den) : r_den[7:0];
                    r_neg <= r_prod[17] ^ r_den[8];
                    r_rem <= '0;
                    r_step <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (rem2 >= {1'b0, r_dmag}) begin
                        r_rem <= rem2 - {1'b0, r_dmag};
                        r_quo <= {r_quo[14:0], 1'b1};
                    end else begin
                        r_rem <= rem2;
                        r_quo <= {r_quo[14:0], 1'b0};
                    end
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd15) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    priority if (rc < 0) begin
                        r_res <= '0;
                    end else if (rc > $signed({10'd0, pli_pkg::Y_MAX})) begin
                        r_res <= pli_pkg::Y_MAX;
                    end else begin
                        r_res <= rc[7:0];
                    end
                    r_st <= pli_pkg::ST_OK;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid = r_ov;
    assign o_result.result_y = r_res;
    assign o_result.status = r_st;
endmodule

/* rtl/piecewise_linear_interp_core.sv */
// piecewise linear interpolation table, top level
// i_item carries one command per item: clear, append point or query at x.
// o_result returns exactly one item per command, result_y and status, in order.
// the front end classifies items and keeps the point count; a two entry
// queue decouples it from the back end, which owns the point memory.
// clear, append and unused codes, and items refused as full or empty, load
// their result as the back end takes them. a query with one point returns
// that point's y; otherwise the scan reads one point a cycle over the single
// ram port until a point at or below query x is found or the last point is
// reached, then the segment is fetched, the product and signs are formed, a
// restoring divider works out the 16 bit quotient and the result saturates.
// one query is worked on at a time.
// synchronous active low reset empties the table and the queue; stored points
// are not cleared and are only read below the point count.
// a stalled receiver holds the result register; the queue keeps taking items
// until it is full, then i_item.ready drops.
module piecewise_linear_interp_core #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pli_in_if.sink    i_item,
    pli_out_if.source o_result
);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int QW = $bits(pli_pkg::t_cmd) + CW;

    logic          full;
    logic          push;
    pli_pkg::t_cmd f_cmd;
    logic [CW-1:0] f_cnt;
    logic          pop;
    logic          q_valid;
    logic [QW-1:0] q_data;
    pli_pkg::t_cmd b_cmd;
    logic [CW-1:0] b_cnt;

    pli_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (f_cmd),
        .o_cnt   (f_cnt)
    );

    pli_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cmd, f_cnt}),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign b_cmd = q_data[QW-1:CW];
    assign b_cnt = q_data[CW-1:0];

    pli_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_cmd    (b_cmd),
        .i_cnt    (b_cnt),
        .o_pop    (pop),
        .o_result (o_result)
    );
endmodule
